// ----- hdl/swtm_pkg.sv -----
`default_nettype none
package swtm_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned SUM_W    = 18;

    localparam logic [CFG_W-1:0] LEN_RST = 5'd10;
    localparam logic [CFG_W-1:0] LEN_MIN = 5'd3;

    // ceil(2^19 / 3): exact quotient for every 18-bit dividend
    localparam logic [SUM_W-1:0] RECIP3   = 18'd174763;
    localparam int unsigned      RECIP_SH = 19;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAP,
        S_SUM,
        S_MUL
    } t_state;

    // what a cell tells its neighbours about the coming transfer
    typedef struct packed {
        logic to_right;
        logic to_left;
        logic carry;
    } t_link;

endpackage
`default_nettype wire

// ----- hdl/swtm_cell.sv -----
`default_nettype none
module swtm_cell
    import swtm_pkg::*;
#(
    parameter int unsigned TAG_W = 4
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_clr,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire logic [TAG_W-1:0]    i_slot,
    input  wire logic [SAMPLE_W-1:0] i_left_value,
    input  wire logic [TAG_W-1:0]    i_left_tag,
    input  wire logic                i_left_valid,
    input  wire t_link               i_left_link,
    input  wire logic [SAMPLE_W-1:0] i_right_value,
    input  wire logic [TAG_W-1:0]    i_right_tag,
    input  wire logic                i_right_valid,
    input  wire t_link               i_right_link,
    output logic [SAMPLE_W-1:0]      o_value,
    output logic [TAG_W-1:0]         o_tag,
    output logic                     o_valid,
    output t_link                    o_link
);

    logic [SAMPLE_W-1:0] r_value, n_value;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic                r_valid, n_valid;
    logic                w_gt, w_del, w_after_del, w_keep;

    always_comb begin
        // empty cells sit above every sample so the row stays ordered
        w_gt        = !r_valid || (r_value > i_sample);
        w_del       = r_valid && (r_tag == i_slot);
        w_after_del = i_left_link.carry;
        w_keep      = (w_after_del == w_gt) && !w_del;

        o_link.carry    = w_after_del | w_del;
        o_link.to_right = !w_after_del && w_gt && !w_del;
        o_link.to_left  = w_after_del && !w_gt && !w_del;
    end

    always_comb begin
        if (w_keep) begin
            n_value = r_value;
            n_tag   = r_tag;
            n_valid = r_valid;
        end else if (i_left_link.to_right) begin
            n_value = i_left_value;
            n_tag   = i_left_tag;
            n_valid = i_left_valid;
        end else if (i_right_link.to_left) begin
            n_value = i_right_value;
            n_tag   = i_right_tag;
            n_valid = i_right_valid;
        end else begin
            n_value = i_sample;
            n_tag   = i_slot;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= n_value;
            r_tag   <= n_tag;
        end
    end

    assign o_value = r_value;
    assign o_tag   = r_tag;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

// ----- hdl/sorted_window_trimmed_mean.sv -----
`default_nettype none
// running trimmed-mean filter over a sorted sample window
//
// input stream: i_s_axis_* carries one unsigned 16-bit sample per transfer.
// output stream: o_m_axis_* carries one result per input sample; tdata is the
// filtered value, tuser is the warm-up flag (1 while the window is still
// filling and the sample is passed through unchanged).
// config: i_cfg_data sets the window length (clamped to 3..MAX_WINDOW). A write
// clears the window and restarts warm-up. Write only while no sample is in flight.
//
// the window lives in a row of MAX_WINDOW cells kept in sorted order; each
// accepted sample drops the oldest entry and is inserted in the same cycle as its transfer.
// the centre taps are then registered (S_TAP), summed (S_SUM) and scaled into
// the output register (S_MUL); a new sample is taken only once the previous one
// has left S_MUL. the input side reopens while a result still waits in the
// output register; a stalled receiver holds the next result in the scaling
// stage until the output register frees.
// reset: window length 10, window empty, both streams idle.
module sorted_window_trimmed_mean
    import swtm_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [SAMPLE_W-1:0] i_s_axis_tdata,  // [15:0] sample
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [SAMPLE_W-1:0]      o_m_axis_tdata,  // [15:0] filtered
    output logic [0:0]               o_m_axis_tuser,  // [0] warming
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CFG_W-1:0]    i_cfg_data       // [4:0] window_len
);

    localparam int unsigned TAG_W = $clog2(MAX_WINDOW);
    localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned TIX_W = LEN_W + 1;
    localparam int unsigned CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int unsigned NTAPS = 4;

    t_state r_state, n_state;

    logic [CFG_W-1:0]          r_len;
    logic [TAG_W-1:0]          r_slot;
    logic                      r_full;
    logic [SAMPLE_W-1:0]       r_samp;
    logic                      r_warm;
    logic [SAMPLE_W-1:0]       r_tap [NTAPS];
    logic [SUM_W-1:0]          r_sum;
    logic                      r_out_valid;
    logic [SAMPLE_W-1:0]       r_out_data;
    logic                      r_out_warm;

    logic                      w_in_xfer, w_cfg_xfer, w_out_free;
    logic                      w_ready, w_load_tap, w_load_sum, w_load_out;
    logic [CMP_W-1:0]          w_len_ext;
    logic [LEN_W-1:0]          w_len;
    logic [TAG_W-1:0]          w_slot;
    logic [LEN_W-1:0]          w_slot_inc;
    logic                      w_wrap;
    logic [TIX_W-1:0]          w_mid;
    logic [SAMPLE_W-1:0]       w_tap [NTAPS];
    logic [2*SUM_W-1:0]        w_prod;
    logic [SAMPLE_W-1:0]       w_result;

    logic [SAMPLE_W-1:0]       w_value [MAX_WINDOW];
    logic [TAG_W-1:0]          w_tag   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]     w_valid;
    t_link                     w_link  [MAX_WINDOW];

    assign w_cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // effective window length and write slot
    always_comb begin
        w_len_ext = CMP_W'(r_len);
        if (w_len_ext < CMP_W'(LEN_MIN)) begin
            w_len = LEN_W'(LEN_MIN);
        end else if (w_len_ext > CMP_W'(MAX_WINDOW)) begin
            w_len = LEN_W'(MAX_WINDOW);
        end else begin
            w_len = LEN_W'(w_len_ext);
        end
        w_slot     = (LEN_W'(r_slot) < w_len) ? r_slot : '0;
        w_slot_inc = LEN_W'(w_slot) + LEN_W'(1);
        w_wrap     = (w_slot_inc >= w_len);
        w_mid      = TIX_W'((w_len - LEN_W'(1)) >> 1);
    end

    // sorted row of cells
    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        logic [SAMPLE_W-1:0] w_lv, w_rv;
        logic [TAG_W-1:0]    w_lt, w_rt;
        logic                w_lvld, w_rvld;
        t_link               w_ll, w_rl;

        if (gi == 0) begin : g_first
            assign w_lv   = '0;
            assign w_lt   = '0;
            assign w_lvld = 1'b0;
            assign w_ll   = '0;
        end else begin : g_mid_l
            assign w_lv   = w_value[gi-1];
            assign w_lt   = w_tag[gi-1];
            assign w_lvld = w_valid[gi-1];
            assign w_ll   = w_link[gi-1];
        end

        if (gi == MAX_WINDOW - 1) begin : g_last
            assign w_rv   = '0;
            assign w_rt   = '0;
            assign w_rvld = 1'b0;
            assign w_rl   = '0;
        end else begin : g_mid_r
            assign w_rv   = w_value[gi+1];
            assign w_rt   = w_tag[gi+1];
            assign w_rvld = w_valid[gi+1];
            assign w_rl   = w_link[gi+1];
        end

        swtm_cell #(
            .TAG_W(TAG_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_in_xfer),
            .i_clr        (w_cfg_xfer),
            .i_sample     (i_s_axis_tdata),
            .i_slot       (w_slot),
            .i_left_value (w_lv),
            .i_left_tag   (w_lt),
            .i_left_valid (w_lvld),
            .i_left_link  (w_ll),
            .i_right_value(w_rv),
            .i_right_tag  (w_rt),
            .i_right_valid(w_rvld),
            .i_right_link (w_rl),
            .o_value      (w_value[gi]),
            .o_tag        (w_tag[gi]),
            .o_valid      (w_valid[gi]),
            .o_link       (w_link[gi])
        );
    end

    // centre taps mid-1 .. mid+2, picked by and-or over the row
    always_comb begin
        for (int k = 0; k < NTAPS; k++) begin
            w_tap[k] = '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                if (TIX_W'(i) == (w_mid - TIX_W'(1) + TIX_W'(k))) begin
                    w_tap[k] = w_tap[k] | w_value[i];
                end
            end
        end
    end

    assign w_prod   = r_sum * RECIP3;
    assign w_result = r_warm ? r_samp
                    : (w_len[0] ? w_prod[RECIP_SH +: SAMPLE_W] : r_sum[2 +: SAMPLE_W]);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_TAP;
                end
            end
            S_TAP: n_state = S_SUM;
            S_SUM: n_state = S_MUL;
            S_MUL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready    = 1'b0;
        w_load_tap = 1'b0;
        w_load_sum = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: w_ready    = 1'b1;
            S_TAP:  w_load_tap = 1'b1;
            S_SUM:  w_load_sum = 1'b1;
            S_MUL:  w_load_out = w_out_free;
            default: w_ready   = 1'b0;
        endcase
    end

    assign o_s_axis_tready = w_ready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RST;
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_xfer) begin
                r_len  <= i_cfg_data;
                r_slot <= '0;
                r_full <= 1'b0;
            end else if (w_in_xfer) begin
                r_slot <= w_wrap ? '0 : TAG_W'(w_slot_inc);
                if (w_wrap) begin
                    r_full <= 1'b1;
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_samp <= i_s_axis_tdata;
            r_warm <= !(r_full || w_wrap);
        end
        if (w_load_tap) begin
            for (int k = 0; k < NTAPS; k++) begin
                r_tap[k] <= w_tap[k];
            end
        end
        if (w_load_sum) begin
            r_sum <= SUM_W'(r_tap[0]) + SUM_W'(r_tap[1]) + SUM_W'(r_tap[2])
                   + (w_len[0] ? '0 : SUM_W'(r_tap[3]));
        end
        if (w_load_out) begin
            r_out_data <= w_result;
            r_out_warm <= r_warm;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_warm;

    // checks on the cell row
    logic [MAX_WINDOW-1:0] w_order_ok;

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (i == MAX_WINDOW - 1) begin
                w_order_ok[i] = 1'b1;
            end else begin
                w_order_ok[i] = !w_valid[i+1] || (w_value[i] <= w_value[i+1]);
            end
        end
    end

    a_row_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&w_order_ok))
        else $error("cell row out of order");

    a_row_packed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid & (w_valid + MAX_WINDOW'(1))) == '0))
        else $error("occupied cells not packed at the low end");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_valid) <= w_len))
        else $error("more occupied cells than the window length");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_state == S_TAP) |-> ($countones(w_valid) == w_len))
        else $error("full window does not hold exactly its length");

endmodule
`default_nettype wire
